FILE: hw/rtl/wmo_pkg.sv
// Shared widths, codes and types for the wavetable morph oscillator.
package wmo_pkg;

   localparam int ADDR_W    = 14;
   localparam int TABLE_DEPTH = 1 << ADDR_W;
   localparam int SAMPLE_W  = 16;
   localparam int PHASE_W   = 24;
   localparam int MORPH_W   = 16;
   localparam int SLOPE_W   = 16;
   localparam int TDATA_W   = 72;
   localparam int RSP_W     = 16;

   localparam int WAVE_LEN_DEFAULT   = 256;
   localparam int WAVE_COUNT_DEFAULT = 64;

   localparam logic [SLOPE_W-1:0] SLOPE_FLOOR_RESET = 16'd3;

   // result queue; input credits track it
   localparam int OFIFO_DEPTH = 8;
   localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
   localparam int CRED_W      = $clog2(OFIFO_DEPTH + 1);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_GEN   = 1'b1
   } op_type;

   // sideband that travels with each table read
   typedef struct packed {
      logic               valid;
      logic               second;  // upper neighbor of the pair
      logic               wave_b;  // second wave of a crossfade
      logic               single;  // edge wave, no crossfade
      logic [PHASE_W-1:0] fx;
      logic [MORPH_W-1:0] f;
   } rd_tag_type;

endpackage

FILE: hw/rtl/wmo_table.sv
// Single-port sample memory with a registered read.
module wmo_table (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [wmo_pkg::ADDR_W-1:0]   addr,
   input  logic [wmo_pkg::SAMPLE_W-1:0] wr_data,
   output logic [wmo_pkg::SAMPLE_W-1:0] rd_data
);
   import wmo_pkg::*;

   logic [SAMPLE_W-1:0] sample_mem [TABLE_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem[addr] <= wr_data;
      end else if (rd_en) begin
         rd_data_ff <= sample_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/wmo_interp.sv
// Interpolation and crossfade pipeline fed by the table read stream.
module wmo_interp (
   input  logic                         clock,
   input  logic                         reset,
   input  wmo_pkg::rd_tag_type          tag_in,
   input  logic [wmo_pkg::SAMPLE_W-1:0] rd_data,
   input  logic [wmo_pkg::SLOPE_W-1:0]  slope_floor,
   output logic                         out_valid,
   output logic [wmo_pkg::SAMPLE_W-1:0] out_signal
);
   import wmo_pkg::*;

   localparam logic signed [19:0] SAT_MAX = 20'sd32767;
   localparam logic signed [19:0] SAT_MIN = -20'sd32768;

   rd_tag_type tag_ff;
   logic signed [SAMPLE_W-1:0] y1_ff;

   // pair stage
   logic signed [16:0] d_in;
   logic        [16:0] ad_in;
   logic               flat_in;
   logic signed [41:0] p1_prod_in;
   logic               p1_valid_ff;
   logic signed [41:0] p1_prod_ff;
   logic signed [17:0] p1_y1_ff;
   logic               p1_flat_ff;
   logic               p1_final_ff;
   logic               p1_single_ff;
   logic [MORPH_W-1:0] p1_f_ff;

   // wave value stage
   logic signed [17:0] p2_v_in;
   logic               p2_valid_ff;
   logic signed [17:0] p2_v_ff;
   logic               p2_final_ff;
   logic               p2_single_ff;
   logic [MORPH_W-1:0] p2_f_ff;
   logic signed [17:0] va_ff;

   // crossfade stage
   logic signed [17:0] v1_in;
   logic signed [18:0] diff_in;
   logic [MORPH_W-1:0] fsel_in;
   logic signed [35:0] p3_prod_in;
   logic               p3_valid_ff;
   logic signed [35:0] p3_prod_ff;
   logic signed [17:0] p3_v1_ff;

   logic signed [19:0] sum_in;
   logic [SAMPLE_W-1:0] out_in;
   logic               out_valid_ff;
   logic [SAMPLE_W-1:0] out_ff;

   always_comb begin
      d_in       = $signed({rd_data[SAMPLE_W-1], rd_data}) - $signed({y1_ff[SAMPLE_W-1], y1_ff});
      ad_in      = d_in[16] ? 17'(-d_in) : 17'(d_in);
      flat_in    = ad_in < {1'b0, slope_floor};
      p1_prod_in = d_in * $signed({1'b0, tag_ff.fx});

      p2_v_in = p1_flat_ff ? p1_y1_ff : p1_y1_ff + p1_prod_ff[41:24];

      v1_in      = p2_single_ff ? p2_v_ff : va_ff;
      diff_in    = $signed({p2_v_ff[17], p2_v_ff}) - $signed({v1_in[17], v1_in});
      fsel_in    = p2_single_ff ? '0 : p2_f_ff;
      p3_prod_in = diff_in * $signed({1'b0, fsel_in});

      sum_in = $signed({{2{p3_v1_ff[17]}}, p3_v1_ff}) + p3_prod_ff[35:16];
      if (sum_in > SAT_MAX) begin
         out_in = SAMPLE_W'(SAT_MAX);
      end else if (sum_in < SAT_MIN) begin
         out_in = SAMPLE_W'(SAT_MIN);
      end else begin
         out_in = sum_in[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         tag_ff.valid <= tag_in.valid;
         p1_valid_ff  <= tag_ff.valid && tag_ff.second;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff && p2_final_ff;
         out_valid_ff <= p3_valid_ff;
      end
      tag_ff.second <= tag_in.second;
      tag_ff.wave_b <= tag_in.wave_b;
      tag_ff.single <= tag_in.single;
      tag_ff.fx     <= tag_in.fx;
      tag_ff.f      <= tag_in.f;

      if (tag_ff.valid && !tag_ff.second) begin
         y1_ff <= rd_data;
      end
      p1_prod_ff   <= p1_prod_in;
      p1_y1_ff     <= 18'(y1_ff);
      p1_flat_ff   <= flat_in;
      p1_final_ff  <= tag_ff.single || tag_ff.wave_b;
      p1_single_ff <= tag_ff.single;
      p1_f_ff      <= tag_ff.f;

      p2_v_ff      <= p2_v_in;
      p2_final_ff  <= p1_final_ff;
      p2_single_ff <= p1_single_ff;
      p2_f_ff      <= p1_f_ff;
      // first wave of a crossfade waits here for the second
      if (p2_valid_ff && !p2_final_ff) begin
         va_ff <= p2_v_ff;
      end

      p3_prod_ff <= p3_prod_in;
      p3_v1_ff   <= v1_in;
      out_ff     <= out_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_signal = out_ff;

endmodule

FILE: hw/rtl/wmo_ofifo.sv
// Result queue between the datapath and the output channel.
module wmo_ofifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [wmo_pkg::RSP_W-1:0] push_data,
   input  logic                      pop,
   output logic                      out_valid,
   output logic [wmo_pkg::RSP_W-1:0] out_data
);
   import wmo_pkg::*;

   logic [RSP_W-1:0]       entry_ff [OFIFO_DEPTH];
   logic [OFIFO_PTR_W-1:0] wr_ptr_ff;
   logic [OFIFO_PTR_W-1:0] rd_ptr_ff;
   logic [CRED_W-1:0]      count_ff;
   logic                   pop_ok;

   assign pop_ok = pop && (count_ff != '0);

   // no full check: the input credit keeps the fill at or below depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OFIFO_PTR_W'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + OFIFO_PTR_W'(1);
         end
         count_ff <= count_ff + CRED_W'(push) - CRED_W'(pop_ok);
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];

endmodule

FILE: hw/rtl/wavetable_morph_oscillator.sv
// Table port: one port; a crossfade issues four reads, an edge
//   wave two reads, a table write one write, issued back to back.
// Input stalls when 8 results are in flight or waiting, or while the issue stage is
//   busy and the two stages ahead of it are both full.
// Reset: synchronous, active high; clears valids, credits, queue, slope_floor to 3.
module wavetable_morph_oscillator #(
   parameter int WAVE_LEN   = wmo_pkg::WAVE_LEN_DEFAULT,
   parameter int WAVE_COUNT = wmo_pkg::WAVE_COUNT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // tdata: sample_addr[13:0], sample_value[29:14], phase[53:30], morph[69:54], zero pad
   input  logic [wmo_pkg::TDATA_W-1:0] req_tdata,
   // tuser: op (0 write, 1 generate)
   input  logic [0:0]                  req_tuser,
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // tdata: signal[15:0]
   output logic [wmo_pkg::RSP_W-1:0]   rsp_tdata,
   // slope_floor register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [wmo_pkg::SLOPE_W-1:0] csr_data
);
   import wmo_pkg::*;

   localparam int WLW  = $clog2(WAVE_LEN + 1);
   localparam int NWW  = $clog2(WAVE_COUNT + 1);
   localparam int IDX_W = $clog2(WAVE_LEN);
   localparam int KW   = $clog2(WAVE_COUNT);
   localparam int X_W  = PHASE_W + WLW;
   localparam int W_W  = MORPH_W + NWW;
   localparam int BP_W = KW + WLW;

   // ------------------------------------------------------------------
   // Config register
   // ------------------------------------------------------------------
   logic [SLOPE_W-1:0] slope_floor_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_floor_ff <= SLOPE_FLOOR_RESET;
      end else if (csr_valid) begin
         slope_floor_ff <= csr_data;
      end
   end

   // ------------------------------------------------------------------
   // Front pipeline: S1 holds the transfer, S2 the phase/morph products,
   // S3 is the issue stage that owns the table port.
   // ------------------------------------------------------------------
   logic               s1_valid_ff;
   op_type             s1_op_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic [SAMPLE_W-1:0] s1_value_ff;
   logic [PHASE_W-1:0] s1_phase_ff;
   logic [MORPH_W-1:0] s1_morph_ff;

   logic               s2_valid_ff;
   op_type             s2_op_ff;
   logic [ADDR_W-1:0]  s2_addr_ff;
   logic [SAMPLE_W-1:0] s2_value_ff;
   logic [X_W-1:0]     s2_x_ff;
   logic [W_W-1:0]     s2_w_ff;

   logic               s3_valid_ff;
   op_type             s3_op_ff;
   logic [ADDR_W-1:0]  s3_addr_ff;
   logic [SAMPLE_W-1:0] s3_value_ff;
   logic [ADDR_W-1:0]  s3_base_ff;
   logic [IDX_W-1:0]   s3_idx_ff;
   logic [IDX_W-1:0]   s3_nxt_ff;
   logic [PHASE_W-1:0] s3_fx_ff;
   logic [MORPH_W-1:0] s3_f_ff;
   logic               s3_single_ff;
   logic [1:0]         cnt_ff;    // bit 0: upper neighbor, bit 1: second wave

   logic               req_acc;
   logic               credit_ok;
   logic               s1_free, s2_free, s3_free, s3_done;

   // S2 decode
   logic [X_W-1:0]     s2_x_in;
   logic [W_W-1:0]     s2_w_in;
   logic [IDX_W-1:0]   idx_in;
   logic [IDX_W-1:0]   nxt_in;
   logic [KW-1:0]      k_in;
   logic [KW-1:0]      kc_in;
   logic               single_in;
   logic [ADDR_W-1:0]  base_in;

   // issue
   logic [ADDR_W-1:0]  mem_addr;
   logic [ADDR_W-1:0]  wave_off;
   logic [IDX_W-1:0]   pick_idx;
   logic               mem_wr, mem_rd;
   rd_tag_type         tag;

   assign s3_done = s3_valid_ff && ((s3_op_ff == OP_WRITE) ||
                                    (s3_single_ff ? (cnt_ff[0]) : (cnt_ff == 2'b11)));
   assign s3_free = !s3_valid_ff || s3_done;
   assign s2_free = !s2_valid_ff || s3_free;
   assign s1_free = !s1_valid_ff || s2_free;

   assign req_tready = !reset && s1_free && credit_ok;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      s2_x_in = X_W'(s1_phase_ff) * X_W'(WAVE_LEN);
      s2_w_in = W_W'(s1_morph_ff) * W_W'(WAVE_COUNT);

      idx_in = s2_x_ff[PHASE_W +: IDX_W];
      // last sample wraps to index 0
      nxt_in = (idx_in == IDX_W'(WAVE_LEN - 1)) ? '0 : idx_in + IDX_W'(1);
      k_in   = s2_w_ff[MORPH_W +: KW];
      // edge waves go alone; clamp to the last wave
      single_in = (k_in == '0) || (k_in >= KW'(WAVE_COUNT - 1));
      kc_in     = (k_in > KW'(WAVE_COUNT - 1)) ? KW'(WAVE_COUNT - 1) : k_in;
      base_in   = ADDR_W'(BP_W'(kc_in) * BP_W'(WAVE_LEN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_acc;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
            cnt_ff      <= '0;
         end else begin
            cnt_ff <= cnt_ff + 2'd1;
         end
      end

      if (s1_free) begin
         s1_op_ff    <= op_type'(req_tuser[0]);
         s1_addr_ff  <= req_tdata[13:0];
         s1_value_ff <= req_tdata[29:14];
         s1_phase_ff <= req_tdata[53:30];
         s1_morph_ff <= req_tdata[69:54];
      end
      if (s2_free) begin
         s2_op_ff    <= s1_op_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_value_ff <= s1_value_ff;
         s2_x_ff     <= s2_x_in;
         s2_w_ff     <= s2_w_in;
      end
      if (s3_free) begin
         s3_op_ff     <= s2_op_ff;
         s3_addr_ff   <= s2_addr_ff;
         s3_value_ff  <= s2_value_ff;
         s3_base_ff   <= base_in;
         s3_idx_ff    <= idx_in;
         s3_nxt_ff    <= nxt_in;
         s3_fx_ff     <= s2_x_ff[PHASE_W-1:0];
         s3_f_ff      <= s2_w_ff[MORPH_W-1:0];
         s3_single_ff <= single_in;
      end
   end

   // Table port: writes and reads leave S3 in transfer order, so a read
   // always sees every earlier write without forwarding.
   always_comb begin
      mem_wr   = s3_valid_ff && (s3_op_ff == OP_WRITE);
      mem_rd   = s3_valid_ff && (s3_op_ff == OP_GEN);
      wave_off = cnt_ff[1] ? ADDR_W'(WAVE_LEN) : '0;
      pick_idx = cnt_ff[0] ? s3_nxt_ff : s3_idx_ff;
      mem_addr = mem_wr ? s3_addr_ff : s3_base_ff + wave_off + ADDR_W'(pick_idx);

      tag.valid  = mem_rd;
      tag.second = cnt_ff[0];
      tag.wave_b = cnt_ff[1];
      tag.single = s3_single_ff;
      tag.fx     = s3_fx_ff;
      tag.f      = s3_f_ff;
   end

   logic [SAMPLE_W-1:0] rd_data;

   wmo_table u_table (
      .clock   (clock),
      .wr_en   (mem_wr),
      .rd_en   (mem_rd),
      .addr    (mem_addr),
      .wr_data (s3_value_ff),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------
   // Datapath and result queue
   // ------------------------------------------------------------------
   logic                dp_valid;
   logic [SAMPLE_W-1:0] dp_signal;

   wmo_interp u_interp (
      .clock       (clock),
      .reset       (reset),
      .tag_in      (tag),
      .rd_data     (rd_data),
      .slope_floor (slope_floor_ff),
      .out_valid   (dp_valid),
      .out_signal  (dp_signal)
   );

   wmo_ofifo u_ofifo (
      .clock     (clock),
      .reset     (reset),
      .push      (dp_valid),
      .push_data (dp_signal),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

   // Credits: generate items between input transfer and output transfer.
   // Capped at the queue depth, so the queue never overflows.
   logic [CRED_W-1:0] gen_cnt_ff;
   logic              gen_acc;
   logic              rsp_xfer;

   assign gen_acc   = req_acc && (op_type'(req_tuser[0]) == OP_GEN);
   assign rsp_xfer  = rsp_tvalid && rsp_tready;
   assign credit_ok = gen_cnt_ff < CRED_W'(OFIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_cnt_ff <= '0;
      end else begin
         gen_cnt_ff <= gen_cnt_ff + CRED_W'(gen_acc) - CRED_W'(rsp_xfer);
      end
   end

endmodule

FILE: hw/rtl/wmo_checker.sv
// Port-level checks for the wavetable morph oscillator, bound to the top level.
module wmo_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [0:0]                  req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [wmo_pkg::RSP_W-1:0]   rsp_tdata
);
   import wmo_pkg::*;

   logic [CRED_W:0] outstanding_ff;
   logic            gen_xfer;
   logic            rsp_xfer;

   assign gen_xfer = req_tvalid && req_tready && (req_tuser[0] == OP_GEN);
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + (CRED_W+1)'(gen_xfer) - (CRED_W+1)'(rsp_xfer);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> outstanding_ff != '0)
      else $error("result without a pending generate transfer");

   a_credit_cap: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff >= (CRED_W+1)'(OFIFO_DEPTH) |-> !req_tready)
      else $error("input taken with result queue full");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $past(outstanding_ff) == '0 && !$past(gen_xfer) |-> !rsp_tvalid)
      else $error("result appeared with nothing in flight");

endmodule

bind wavetable_morph_oscillator wmo_checker u_wmo_checker (.*);
